/* hw/rtl/rrd_pkg.sv */
// Shared types and constants for the registry record decoder.
package rrd_pkg;

	localparam int unsigned HDR_LEN = 8;
	localparam int unsigned REC_LEN = 16;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_SHORT     = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	typedef struct packed {
		logic        record_present;
		logic [63:0] entity_id;
		logic [63:0] factory_id;
		logic        buffer_done;
		status_t     status;
	} rrd_result_t;

endpackage

/* hw/rtl/rrd_parser.sv */
// Parser state and per-byte header and record checks.
module rrd_parser import rrd_pkg::*; #(
	parameter int unsigned MAX_RECORDS = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        is_last_byte,
	input  logic [31:0] expected_schema,
	output logic        res_valid,
	output rrd_result_t res
);

	localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int unsigned POS_W = $clog2(16 * MAX_RECORDS + 9);

	logic [POS_W-1:0] pos_q;
	logic [55:0]      hdr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      ent_q;
	logic [63:0]      fac_q;
	logic [63:0]      prev_q;
	logic             have_prev_q;
	logic             err_q;

	logic [31:0]      count32;
	logic [CNT_W-1:0] cnt_eff;
	logic [POS_W-1:0] exp_len;
	logic [POS_W-1:0] end_len;
	logic [POS_W-1:0] pos_inc;
	logic [2:0]       lane;
	logic             in_hdr;
	logic             hdr_done;
	logic             hdr_bad;
	logic             overrun;
	logic             is_ent;
	logic             rec_end;
	logic             rec_bad;
	logic             err_now;
	logic             err_nx;
	logic             present;
	logic [63:0]      lane_val;
	logic [63:0]      ent_nx;
	logic [63:0]      fac_nx;

	always_comb begin
		lane     = pos_q[2:0];
		in_hdr   = (pos_q < POS_W'(HDR_LEN));
		hdr_done = (pos_q == POS_W'(HDR_LEN - 1));
		count32  = {data_byte, hdr_q[55:32]};
		hdr_bad  = (hdr_q[31:0] != expected_schema) || (count32 > 32'(MAX_RECORDS));
		// Expected length is 8 + 16 * count, which is the count with 4'b1000 below it.
		exp_len  = POS_W'({cnt_q, 4'b1000});
		overrun  = !in_hdr && (pos_q >= exp_len);
		// Records start at byte 8, so the offset inside a record is pos with bit 3 flipped.
		is_ent   = pos_q[3];
		lane_val = 64'(data_byte) << {lane, 3'b000};
		ent_nx   = is_ent ? (ent_q | lane_val) : ent_q;
		fac_nx   = is_ent ? fac_q : (fac_q | lane_val);
		rec_end  = !in_hdr && !overrun && (pos_q[3:0] == 4'd7);
		rec_bad  = (ent_nx == 64'd0) || (fac_nx == 64'd0) ||
		           (have_prev_q && (prev_q >= ent_nx));
		err_now  = (hdr_done && hdr_bad) || overrun || (rec_end && rec_bad);
		err_nx   = err_q || err_now;
		present  = !err_q && rec_end && !rec_bad;
		pos_inc  = pos_q + 1'b1;
		cnt_eff  = hdr_done ? count32[CNT_W-1:0] : cnt_q;
		end_len  = POS_W'({cnt_eff, 4'b1000});

		res.record_present = present;
		res.entity_id      = present ? ent_nx : 64'd0;
		res.factory_id     = present ? fac_nx : 64'd0;
		res.buffer_done    = is_last_byte;
		if (!is_last_byte) begin
			res.status = STATUS_OK;
		end else if (err_nx) begin
			res.status = STATUS_MALFORMED;
		end else if (pos_q < POS_W'(HDR_LEN - 1)) begin
			res.status = STATUS_SHORT;
		end else if (pos_inc == end_len) begin
			res.status = STATUS_OK;
		end else begin
			res.status = STATUS_MALFORMED;
		end
		res_valid = present || is_last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_q       <= '0;
			cnt_q       <= '0;
			ent_q       <= '0;
			fac_q       <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			err_q       <= 1'b0;
		end else if (step) begin
			if (is_last_byte) begin
				pos_q       <= '0;
				hdr_q       <= '0;
				cnt_q       <= '0;
				ent_q       <= '0;
				fac_q       <= '0;
				prev_q      <= '0;
				have_prev_q <= 1'b0;
				err_q       <= 1'b0;
			end else if (!err_q) begin
				if (in_hdr) begin
					if (hdr_done) begin
						cnt_q <= count32[CNT_W-1:0];
					end else begin
						hdr_q <= hdr_q | lane_val[55:0];
					end
				end else if (!overrun) begin
					if (rec_end) begin
						ent_q <= '0;
						fac_q <= '0;
						if (!rec_bad) begin
							prev_q      <= ent_nx;
							have_prev_q <= 1'b1;
						end
					end else begin
						ent_q <= ent_nx;
						fac_q <= fac_nx;
					end
				end
				err_q <= err_now;
				if (!err_now) begin
					pos_q <= pos_inc;
				end
			end
		end
	end

endmodule

/* hw/rtl/registry_record_decoder_unit.sv */
// Top level of the registry record decoder: input register, parser and result register.
//
// The block takes a little-endian buffer one byte per request on the s_ channel,
// with s_tlast on the final byte. The header is a 32-bit schema word that must
// equal the configured schema version and a 32-bit record count that must not
// exceed MAX_RECORDS. Each 16-byte record is a 64-bit entity and a 64-bit factory.
// A record that passes its checks leaves on the m_ channel as it completes, and
// the final byte always gives one result with m_tlast high and the status in
// m_tuser. After an error the rest of the buffer is ignored until its final byte.
// A byte enters the input register, is parsed by the combinational parser logic
// once the result register can take its result, and that result is captured in
// the result register, which drives the m_ channel. One byte per cycle is taken
// while the receiver does not stall; the parser updates its state on each step.
// When the receiver stalls, the result register holds and an empty input register
// takes one more byte before s_tready falls. Reset clears all parser state and sets
// the schema version to 1. Write the version through cfg_we and cfg_wdata only while
// no buffer is in progress; the block itself does not enforce this.
module registry_record_decoder_unit import rrd_pkg::*; #(
	parameter int unsigned MAX_RECORDS = 1048576
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // is_last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] entity_id, [127:64] factory_id
	output logic [2:0]   m_tuser,   // [0] record_present, [2:1] status
	output logic         m_tlast    // buffer_done
);

	logic [31:0] schema_q;
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        out_v_q;
	rrd_result_t out_q;
	logic        can_out;
	logic        step;
	logic        res_valid;
	rrd_result_t res;

	assign can_out  = !out_v_q || m_tready;
	assign step     = v_s1 && can_out;
	assign s_tready = !v_s1 || can_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			schema_q <= 32'd1;
		end else if (cfg_we) begin
			schema_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	rrd_parser #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.data_byte      (byte_s1),
		.is_last_byte   (last_s1),
		.expected_schema(schema_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (can_out) begin
			out_v_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.factory_id, out_q.entity_id};
	assign m_tuser  = {out_q.status, out_q.record_present};
	assign m_tlast  = out_q.buffer_done;

endmodule
